// ===== rtl/core/lcdnw_pkg.sv =====
// Shared types and constants of the character LCD nibble writer.
package lcdnw_pkg;

  localparam int unsigned DELAY_W     = 10;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd41;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_CMD    = 2'd1,
    MODE_DATA   = 2'd2,
    MODE_NIBBLE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic       register_select;
    logic       enable_pin;
    logic [3:0] data_lines;
    logic       busy_res;
    logic       accepted;
  } out_word_t;

endpackage

// ===== rtl/core/lcdnw_seq.sv =====
// Write sequencer: phase, delay counter, pin levels and next result word.
module lcdnw_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  lcdnw_pkg::in_word_t                 item,
  input  logic                                cfg_we,
  input  logic [lcdnw_pkg::DELAY_W-1:0]       cfg_wdata,
  output lcdnw_pkg::out_word_t                res
);
  import lcdnw_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_RS     = 4'd1,
    PH_HI0    = 4'd2,
    PH_HI1    = 4'd3,
    PH_HI2    = 4'd4,
    PH_HI3    = 4'd5,
    PH_EN_HI1 = 4'd6,
    PH_EN_LO1 = 4'd7,
    PH_LO0    = 4'd8,
    PH_LO1    = 4'd9,
    PH_LO2    = 4'd10,
    PH_LO3    = 4'd11,
    PH_EN_HI2 = 4'd12,
    PH_EN_LO2 = 4'd13
  } phase_t;

  logic [DELAY_W-1:0] delay_r;
  phase_t             phase_r, phase_nxt;
  logic [DELAY_W-1:0] wait_r, wait_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic               rs_r, rs_nxt;
  logic               en_r, en_nxt;
  logic [3:0]         db_r, db_nxt;
  logic               busy_r, busy_nxt;

  logic               acc;
  logic               do_enter;
  phase_t             enter_ph;
  logic               rs_val;
  logic [1:0]         line;
  logic [DELAY_W-1:0] delay_load;

  assign delay_load = (delay_r == '0) ? DELAY_W'(1) : delay_r;

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    pend_nxt  = pend_r;
    rs_nxt    = rs_r;
    en_nxt    = en_r;
    db_nxt    = db_r;
    busy_nxt  = busy_r;
    acc       = 1'b0;
    do_enter  = 1'b0;
    enter_ph  = phase_r;
    rs_val    = rs_r;
    line      = 2'd0;
    if (fire) begin
      if (item.mode == MODE_TICK) begin
        if (busy_r) begin
          if (wait_r > DELAY_W'(1)) begin
            wait_nxt = wait_r - DELAY_W'(1);
          end else if (phase_r inside {[PH_RS:PH_EN_HI2]}) begin
            do_enter = 1'b1;
            enter_ph = phase_t'(phase_r + 4'd1);
          end else begin
            phase_nxt = PH_IDLE;
            wait_nxt  = '0;
            busy_nxt  = 1'b0;
          end
        end
      end else if (!busy_r) begin
        acc      = 1'b1;
        busy_nxt = 1'b1;
        do_enter = 1'b1;
        if (item.mode == MODE_NIBBLE) begin
          pend_nxt = {4'd0, item.byte_value[3:0]};
          enter_ph = PH_LO0;
        end else begin
          pend_nxt = item.byte_value;
          enter_ph = PH_RS;
          rs_val   = (item.mode == MODE_DATA);
        end
      end
    end
    if (do_enter) begin
      phase_nxt = enter_ph;
      wait_nxt  = delay_load;
      case (enter_ph)
        PH_RS: begin
          rs_nxt = rs_val;
        end
        PH_HI0, PH_HI1, PH_HI2, PH_HI3: begin
          line         = enter_ph[1:0] - 2'd2;
          db_nxt[line] = pend_nxt[{1'b1, line}];
        end
        PH_LO0, PH_LO1, PH_LO2, PH_LO3: begin
          line         = enter_ph[1:0];
          db_nxt[line] = pend_nxt[{1'b0, line}];
        end
        PH_EN_HI1, PH_EN_HI2: begin
          en_nxt = 1'b1;
        end
        PH_EN_LO1, PH_EN_LO2: begin
          en_nxt = 1'b0;
        end
        default: begin
          phase_nxt = enter_ph;
        end
      endcase
    end
  end

  assign res = '{register_select: rs_nxt, enable_pin: en_nxt, data_lines: db_nxt,
                 busy_res: busy_nxt, accepted: acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
      phase_r <= PH_IDLE;
      wait_r  <= '0;
      pend_r  <= '0;
      rs_r    <= 1'b0;
      en_r    <= 1'b0;
      db_r    <= '0;
      busy_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        delay_r <= cfg_wdata;
      end
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      pend_r  <= pend_nxt;
      rs_r    <= rs_nxt;
      en_r    <= en_nxt;
      db_r    <= db_nxt;
      busy_r  <= busy_nxt;
    end
  end

  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (phase_r != PH_IDLE))
    else $error("busy flag and phase disagree");

  a_en_phase: assert property (@(posedge clk) disable iff (!rst_n)
    en_r == (phase_r == PH_EN_HI1 || phase_r == PH_EN_HI2))
    else $error("enable level outside an enable-high phase");

  a_wait_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (wait_r != '0))
    else $error("running write with empty wait count");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && busy_r && item.mode != MODE_TICK) |=> $stable(phase_r) && $stable(wait_r))
    else $error("rejected request changed the sequence");

endmodule

// ===== rtl/core/char_lcd_nibble_writer.sv =====
// Top level of the character LCD nibble writer: input and result registers around the sequencer.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_data   (mode, byte_value)
//   out_     output     out_valid / out_stall out_data  (pins, busy_res, accepted)
//   cfg_     input      cfg_we                cfg_wdata (step_delay_ticks)
//
// One word per cycle while out_stall is low; an accepted input word passes the input register,
// and its result word is registered in the result register around the sequencer.
// Synchronous active-low reset clears the pins, the phase and both valid flags;
// the step delay resets to 41 ticks.
// A stalled result holds the sequencer and the input register; in_stall rises
// only while the input register is full and cannot advance.
module char_lcd_nibble_writer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lcdnw_pkg::in_word_t           in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lcdnw_pkg::out_word_t          out_data,
  input  logic                          cfg_we,
  input  logic [lcdnw_pkg::DELAY_W-1:0] cfg_wdata
);
  import lcdnw_pkg::*;

  logic      in_valid_r;
  in_word_t  in_data_r;
  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t res;
  logic      adv;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  lcdnw_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (adv),
    .item      (in_data_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
